[sv/ack_retransmit_table_core_assert.svh]
// Assertion macros used by the ack retransmit table sequencer.
`ifndef ACK_RETRANSMIT_TABLE_CORE_ASSERT_SVH
`define ACK_RETRANSMIT_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define ARC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ack table assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define ARC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ack table assertion failed");
`else
`define ARC_ASSERT_NOW(lbl, ante, cons)
`define ARC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/arc_pkg.sv]
// Types, constants and helpers shared by the ack retransmit table modules.
package arc_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1500;
  localparam logic [3:0]  MAX_RETRIES_RESET = 4'd3;

  localparam logic [1:0] ACT_PUBLISH = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;

  localparam logic [2:0] KIND_SEND_NEW  = 3'd0;
  localparam logic [2:0] KIND_RESEND    = 3'd1;
  localparam logic [2:0] KIND_SPILL     = 3'd2;
  localparam logic [2:0] KIND_ACK_CLEAR = 3'd3;
  localparam logic [2:0] KIND_ACK_MISS  = 3'd4;

  localparam logic REG_ACK_TIMEOUT = 1'b0;
  localparam logic REG_MAX_RETRIES = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] packet_id;
    logic [31:0] now_ms;
    logic        link_up;
    logic        send_accepted;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [31:0] out_packet_id;
    logic [3:0]  retry_count;
    logic        last;
  } out_t;

  // Contents of one table slot.
  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [31:0] sent_time;
    logic [3:0]  retries;
  } entry_t;

  // Control from the sequencer to the ring of slot cells.
  typedef struct packed {
    logic   shift;
    entry_t wb;
  } ring_ctl_t;

  function automatic out_t mk_out(logic [2:0] kind, logic [2:0] slot,
                                  logic [31:0] id, logic [3:0] retries);
    out_t r;
    r.kind          = kind;
    r.slot          = slot;
    r.out_packet_id = id;
    r.retry_count   = retries;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

[sv/arc_cell.sv]
// One slot cell of the rotating table ring.
module arc_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  arc_pkg::entry_t d,
  output arc_pkg::entry_t q
);
  import arc_pkg::*;

  entry_t ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (shift) begin
      ent.valid <= d.valid;
    end
    if (shift) begin
      ent.id        <= d.id;
      ent.sent_time <= d.sent_time;
      ent.retries   <= d.retries;
    end
  end

  assign q = ent;

endmodule

[sv/arc_ctrl.sv]
// Sequencer: walks the slot ring, decides updates and queues result beats.
`include "ack_retransmit_table_core_assert.svh"
module arc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  arc_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output arc_pkg::out_t      out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  arc_pkg::entry_t    head,
  output arc_pkg::ring_ctl_t ring
);
  import arc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PASS1, ST_PASS2, ST_FLUSH} state_t;

  state_t            state;
  in_t               in_q;
  logic [SLOT_W-1:0] idx;
  logic              found;
  logic [SLOT_W-1:0] tgt;
  logic [3:0]        ack_ret;
  logic [31:0]       best_age;
  logic [SLOT_W-1:0] ev_idx;
  logic [31:0]       ev_id;
  logic [3:0]        ev_ret;
  out_t              pend;
  logic              pend_valid;
  logic [15:0]       ack_timeout;
  logic [3:0]        max_retries;

  logic              in_fire;
  logic              step_go;
  logic              last_step;
  logic [31:0]       age;
  logic              older;
  logic              free_hit;
  logic              match;
  logic              timed_out;
  logic [SLOT_W-1:0] sel_idx;
  logic [31:0]       sel_id;
  logic [3:0]        sel_ret;
  logic              emit;
  out_t              emit_r;
  entry_t            wb;
  logic              out_free;
  logic              out_load;
  out_t              load_data;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign last_step = (idx == SLOT_W'(SLOTS - 1));
  // A step moves the ring by one cell; it waits only when a queued beat
  // cannot be handed to the output register.
  assign step_go   = ((state == ST_PASS1) || (state == ST_PASS2)) &&
                     !(pend_valid && !out_free);

  assign age       = in_q.now_ms - head.sent_time;
  assign older     = (age >= best_age);
  assign free_hit  = !head.valid && !found;
  assign match     = head.valid && (head.id == in_q.packet_id) &&
                     (in_q.packet_id != '0) && !found;
  assign timed_out = head.valid && (age >= 32'(ack_timeout));
  assign sel_idx   = older ? idx : ev_idx;
  assign sel_id    = older ? head.id : ev_id;
  assign sel_ret   = older ? head.retries : ev_ret;

  always_comb begin
    wb     = head;
    emit   = 1'b0;
    emit_r = '0;
    if (state == ST_PASS1) begin
      case (in_q.action)
        ACT_PUBLISH: begin
          // Table full: the oldest slot, highest index on ties, is spilled.
          if (last_step && !found && !free_hit) begin
            emit   = 1'b1;
            emit_r = mk_out(KIND_SPILL, 3'(sel_idx), sel_id, sel_ret);
          end
        end
        ACT_ACK: begin
          if (match) begin
            wb = '0;
          end
          if (last_step) begin
            emit = 1'b1;
            if (match) begin
              emit_r = mk_out(KIND_ACK_CLEAR, 3'(idx), in_q.packet_id, head.retries);
            end else if (found) begin
              emit_r = mk_out(KIND_ACK_CLEAR, 3'(tgt), in_q.packet_id, ack_ret);
            end else begin
              emit_r = mk_out(KIND_ACK_MISS, 3'd0, in_q.packet_id, 4'd0);
            end
          end
        end
        ACT_TICK: begin
          if (timed_out) begin
            emit = 1'b1;
            if (head.retries >= max_retries) begin
              wb     = '0;
              emit_r = mk_out(KIND_SPILL, 3'(idx), head.id, head.retries);
            end else begin
              wb.retries   = head.retries + 4'd1;
              wb.sent_time = in_q.now_ms;
              emit_r = mk_out(KIND_RESEND, 3'(idx), head.id, head.retries + 4'd1);
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else if (state == ST_PASS2) begin
      if (idx == tgt) begin
        emit = 1'b1;
        if (in_q.send_accepted) begin
          wb.valid     = 1'b1;
          wb.id        = in_q.packet_id;
          wb.sent_time = in_q.now_ms;
          wb.retries   = 4'd0;
          emit_r = mk_out(KIND_SEND_NEW, 3'(tgt), in_q.packet_id, 4'd0);
        end else begin
          wb     = '0;
          emit_r = mk_out(KIND_SPILL, 3'(tgt), in_q.packet_id, 4'd0);
        end
      end
    end
  end

  assign ring.shift = step_go;
  assign ring.wb    = wb;

  // The held beat goes out with last low when another beat follows it,
  // and with last high when the item is finished.
  always_comb begin
    out_load  = 1'b0;
    load_data = pend;
    if (step_go && emit && pend_valid) begin
      out_load = 1'b1;
    end else if ((state == ST_FLUSH) && out_free) begin
      out_load       = 1'b1;
      load_data.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      ack_timeout <= ACK_TIMEOUT_RESET;
      max_retries <= MAX_RETRIES_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACK_TIMEOUT: ack_timeout <= cfg_data;
          REG_MAX_RETRIES: max_retries <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= load_data;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            in_q     <= in_data;
            found    <= 1'b0;
            best_age <= '0;
            ev_idx   <= '0;
            idx      <= '0;
            if ((in_data.action == ACT_PUBLISH) && !in_data.link_up) begin
              pend       <= mk_out(KIND_SPILL, 3'd0, in_data.packet_id, 4'd0);
              pend_valid <= 1'b1;
              state      <= ST_FLUSH;
            end else if ((in_data.action == ACT_PUBLISH) ||
                         (in_data.action == ACT_ACK) ||
                         ((in_data.action == ACT_TICK) && in_data.link_up)) begin
              state <= ST_PASS1;
            end
          end
        end
        ST_PASS1, ST_PASS2: begin
          if (step_go) begin
            idx <= last_step ? '0 : idx + SLOT_W'(1);
            if (emit) begin
              pend       <= emit_r;
              pend_valid <= 1'b1;
            end
            if (state == ST_PASS1) begin
              if (free_hit && (in_q.action == ACT_PUBLISH)) begin
                found <= 1'b1;
                tgt   <= idx;
              end
              if (match && (in_q.action == ACT_ACK)) begin
                found   <= 1'b1;
                tgt     <= idx;
                ack_ret <= head.retries;
              end
              if (older) begin
                best_age <= age;
                ev_idx   <= idx;
                ev_id    <= head.id;
                ev_ret   <= head.retries;
              end
              if (last_step && (in_q.action == ACT_PUBLISH) && !found && !free_hit) begin
                tgt <= sel_idx;
              end
            end
            if (last_step) begin
              if ((state == ST_PASS1) && (in_q.action == ACT_PUBLISH)) begin
                state <= ST_PASS2;
              end else if (pend_valid || emit) begin
                state <= ST_FLUSH;
              end else begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ARC_ASSERT_NOW(a_idle_no_pending, state == ST_IDLE, !pend_valid)
  `ARC_ASSERT_NOW(a_idle_ring_home, state == ST_IDLE, idx == '0)
  `ARC_ASSERT_NOW(a_load_into_free, out_load, out_free)
  `ARC_ASSERT_NEXT(a_publish_scans,
                   in_fire && (in_data.action == ACT_PUBLISH) && in_data.link_up,
                   state == ST_PASS1)
  `ARC_ASSERT_NOW(a_flush_has_beat, state == ST_FLUSH, pend_valid)

endmodule

[sv/ack_retransmit_table_core.sv]
// Top level of the ack retransmit table: a ring of slot cells and its sequencer.
//
// Usage: input beats (publish, ack, tick) arrive on in_valid/in_ready/in_data;
// result beats leave on out_valid/out_ready/out_data, the final beat of an
// input carrying last high. Configuration is written through cfg_we,
// cfg_index and cfg_data (index 0 ack timeout in ms, index 1 retry limit)
// while the block is idle.
// The eight slots sit in a ring of cells that rotates by one cell per cycle
// while the output does not stall it, past a single compare and update unit.
// An ack, or a tick with the link up, takes one pass over the ring and then
// releases its last beat, if it has one; a publish with the link up takes two
// passes (search, then write); a publish with the link down releases its spill
// beat without a pass, and a tick with the link down or an ignored action ends
// without a pass or a beat. in_ready is high whenever no item is in progress,
// even while a result beat waits in the output register.
// Reset (synchronous, active high) empties every slot and loads the register
// defaults of 1500 ms and 3 retries. When the receiver stalls, the ring stops
// as soon as one further beat is held back, and resumes without loss.
module ack_retransmit_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  arc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output arc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);
  import arc_pkg::*;

  entry_t    cell_q [SLOTS];
  entry_t    cell_d [SLOTS];
  ring_ctl_t ring;

  // Cell 0 is the head seen by the sequencer; the updated head value
  // re-enters at the tail, so after a full pass every slot is home again.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      assign cell_d[i] = ring.wb;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end
    arc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ring.shift),
      .d     (cell_d[i]),
      .q     (cell_q[i])
    );
  end

  arc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (cell_q[0]),
    .ring      (ring)
  );

endmodule

[sim/ack_retransmit_table_core_tb.sv]
// Self-checking testbench for the ack retransmit table core.
`timescale 1ns / 100ps

module ack_retransmit_table_core_tb;
  import arc_pkg::*;

  // The block ignores the fourth action code; the package has no name for it.
  localparam logic [1:0] ACT_IGNORED = 2'd3;
  // Two passes over the ring plus the final beat, with a generous margin.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 65;

  // Table mirror: tracks the slots, predicts the result beats of each input beat
  // and checks the beats that leave the block against them in order.
  class retransmit_tracker;
    bit        occupied [SLOTS];
    bit [31:0] held_id  [SLOTS];
    bit [31:0] sent_at  [SLOTS];
    bit [3:0]  tries    [SLOTS];
    bit [15:0] timeout_ms;
    bit [3:0]  retry_limit;
    out_t      due[$];
    out_t      burst[$];
    int        mismatches;
    int        beats_seen;
    int        items_seen;

    function new();
      for (int i = 0; i < SLOTS; i++) free_slot(i);
      timeout_ms  = ACK_TIMEOUT_RESET;
      retry_limit = MAX_RETRIES_RESET;
    endfunction

    function void free_slot(int i);
      occupied[i] = 1'b0;
      held_id[i]  = '0;
      sent_at[i]  = '0;
      tries[i]    = '0;
    endfunction

    function void set_reg(logic idx, logic [15:0] value);
      if (idx == REG_ACK_TIMEOUT) begin
        timeout_ms = value;
      end else begin
        retry_limit = value[3:0];
      end
    endfunction

    function void add_beat(logic [2:0] kind, int slot, logic [31:0] id, logic [3:0] count);
      out_t b;
      b.kind          = kind;
      b.slot          = 3'(slot);
      b.out_packet_id = id;
      b.retry_count   = count;
      b.last          = 1'b0;
      burst.push_back(b);
    endfunction

    // Gives the id of a random occupied slot, for acks that hit and duplicate publishes; returns 0 if none.
    function bit pick_held(output bit [31:0] id);
      int held[$];
      id = '0;
      for (int i = 0; i < SLOTS; i++) if (occupied[i]) held.push_back(i);
      if (held.size() == 0) return 1'b0;
      id = held_id[held[$urandom_range(held.size() - 1)]];
      return 1'b1;
    endfunction

    function void note_item(in_t it);
      int        pick;
      bit [31:0] age;
      bit [31:0] best;
      out_t      final_beat;
      burst.delete();
      items_seen++;
      pick = -1;
      case (it.action)
        ACT_PUBLISH: begin
          if (!it.link_up) begin
            add_beat(KIND_SPILL, 0, it.packet_id, 4'd0);
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!occupied[i] && pick < 0) pick = i;
            end
            // Full table: evict the oldest send, the highest index winning ties.
            if (pick < 0) begin
              best = '0;
              pick = 0;
              for (int i = 0; i < SLOTS; i++) begin
                age = it.now_ms - sent_at[i];
                if (age >= best) begin
                  best = age;
                  pick = i;
                end
              end
              add_beat(KIND_SPILL, pick, held_id[pick], tries[pick]);
            end
            if (it.send_accepted) begin
              occupied[pick] = 1'b1;
              held_id[pick]  = it.packet_id;
              sent_at[pick]  = it.now_ms;
              tries[pick]    = '0;
              add_beat(KIND_SEND_NEW, pick, it.packet_id, 4'd0);
            end else begin
              free_slot(pick);
              add_beat(KIND_SPILL, pick, it.packet_id, 4'd0);
            end
          end
        end
        ACT_ACK: begin
          if (it.packet_id != 0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (pick < 0 && occupied[i] && held_id[i] == it.packet_id) pick = i;
            end
          end
          if (pick >= 0) begin
            add_beat(KIND_ACK_CLEAR, pick, it.packet_id, tries[pick]);
            free_slot(pick);
          end else begin
            add_beat(KIND_ACK_MISS, 0, it.packet_id, 4'd0);
          end
        end
        ACT_TICK: begin
          if (it.link_up) begin
            for (int i = 0; i < SLOTS; i++) begin
              age = it.now_ms - sent_at[i];
              if (occupied[i] && age >= {16'd0, timeout_ms}) begin
                if (tries[i] >= retry_limit) begin
                  add_beat(KIND_SPILL, i, held_id[i], tries[i]);
                  free_slot(i);
                end else begin
                  tries[i]   = tries[i] + 4'd1;
                  sent_at[i] = it.now_ms;
                  add_beat(KIND_RESEND, i, held_id[i], tries[i]);
                end
              end
            end
          end
        end
        default: ;
      endcase
      if (burst.size() > 0) begin
        final_beat = burst[burst.size() - 1];
        final_beat.last = 1'b1;
        burst[burst.size() - 1] = final_beat;
      end
      foreach (burst[k]) due.push_back(burst[k]);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_beat(out_t got);
      out_t want;
      beats_seen++;
      if (due.size() == 0) begin
        report($sformatf("beat with nothing expected: kind %0d slot %0d id %h",
                         got.kind, got.slot, got.out_packet_id));
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.slot !== want.slot)
        report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
      if (got.out_packet_id !== want.out_packet_id)
        report($sformatf("packet id %h, expected %h", got.out_packet_id, want.out_packet_id));
      if (got.retry_count !== want.retry_count)
        report($sformatf("retry count %0d, expected %0d", got.retry_count, want.retry_count));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_ACK_TIMEOUT;
  logic [15:0] cfg_data = '0;

  retransmit_tracker board;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          settings_used = 1;
  int          cycle_count = 0;
  bit [31:0]   clock_ms;

  ack_retransmit_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_t make_item(logic [1:0] act, logic [31:0] id, logic [31:0] now,
                                    logic up, logic accepted);
    in_t it;
    it.action        = act;
    it.packet_id     = id;
    it.now_ms        = now;
    it.link_up       = up;
    it.send_accepted = accepted;
    return it;
  endfunction

  // Holds the beat on the input channel until it is taken, after an optional gap.
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    board.note_item(it);
  endtask

  // Drains every expected beat, then lets a possible result-free item finish.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] timeout, logic [3:0] limit);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACK_TIMEOUT;
    cfg_data  <= timeout;
    @(posedge clk);
    cfg_index <= REG_MAX_RETRIES;
    cfg_data  <= {12'd0, limit};
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(REG_ACK_TIMEOUT, timeout);
    board.set_reg(REG_MAX_RETRIES, {12'd0, limit});
    settings_used++;
  endtask

  // Mostly well-formed traffic: acks usually name a pending packet and time moves
  // forward by up to one timeout, with the odd jump anywhere in the 32-bit range.
  task automatic send_random();
    in_t       it;
    int        roll;
    int        sub;
    bit [31:0] id;
    if ($urandom_range(99) < 3) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(board.timeout_ms);
    end
    roll = $urandom_range(99);
    sub  = $urandom_range(99);
    it = make_item(ACT_TICK, $urandom, clock_ms, $urandom_range(99) < 90,
                   $urandom_range(99) < 85);
    if (roll < 40) begin
      it.action = ACT_PUBLISH;
      if (sub < 10) begin
        if (board.pick_held(id)) it.packet_id = id;
      end else if (sub < 13) begin
        it.packet_id = '0;
      end
    end else if (roll < 70) begin
      it.action = ACT_ACK;
      if (sub < 65) begin
        if (board.pick_held(id)) it.packet_id = id;
      end else if (sub < 75) begin
        it.packet_id = '0;
      end
    end else if (roll >= 95) begin
      it.action = ACT_IGNORED;
    end
    send_item(it);
  endtask

  // Result side: check every accepted beat, then pick the next ready level.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) board.check_beat(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d beats outstanding",
             cycle_count, board.due.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    bit [31:0] t0;
    board = new();
    t0 = 32'hFFFF_FFF0;
    clock_ms = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset settings of 1500 ms and 3 retries.
    send_item(make_item(ACT_PUBLISH, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1));
    send_item(make_item(ACT_PUBLISH, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_item(make_item(ACT_ACK, 32'h0, t0, 1'b1, 1'b0));
    send_item(make_item(ACT_ACK, 32'h1234_5678, t0, 1'b1, 1'b1));
    send_item(make_item(ACT_IGNORED, 32'hA5A5_5A5A, t0, 1'b1, 1'b1));
    // Fill the table with equal send times just below the wrap point.
    for (int i = 0; i < SLOTS; i++)
      send_item(make_item(ACT_PUBLISH, 32'h100 + i, t0, 1'b1, 1'b1));
    // Full table with tied ages evicts the highest slot.
    send_item(make_item(ACT_PUBLISH, 32'h200, t0 + 4, 1'b1, 1'b1));
    // Full table and a refused send: the oldest is evicted and the new packet spills.
    send_item(make_item(ACT_PUBLISH, 32'h201, t0 + 6, 1'b1, 1'b0));
    // A second copy of a pending id; the ack clears only the lower slot.
    send_item(make_item(ACT_PUBLISH, 32'h103, t0 + 8, 1'b1, 1'b1));
    send_item(make_item(ACT_ACK, 32'h103, t0 + 9, 1'b1, 1'b1));
    send_item(make_item(ACT_TICK, 32'h0, t0 + 5000, 1'b0, 1'b1));
    // Across the wrap: the older slots time out exactly at the limit.
    send_item(make_item(ACT_TICK, 32'h0, t0 + 1500, 1'b1, 1'b1));
    send_item(make_item(ACT_TICK, 32'h0, t0 + 1500, 1'b1, 1'b1));
    // Zero timeout with the limit lowered to zero: every occupied slot spills.
    configure(16'd0, 4'd0);
    send_item(make_item(ACT_TICK, 32'h0, t0 + 1501, 1'b1, 1'b1));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: configure(16'd1, 4'd15);
        1: configure(16'hFFFF, 4'd2);
        2: configure(16'd300, 4'd1);
        default: configure(16'($urandom_range(65535, 1)), 4'($urandom_range(15)));
      endcase
      send_idle_pct  = (phase == 1) ? 87 : (phase == 3) ? 14 : 0;
      recv_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 14 : 0;
      repeat (ITEMS_PER_PHASE) send_random();
    end
    quiesce();

    $display("Drove %0d input beats and checked %0d result beats over %0d table settings,",
             board.items_seen, board.beats_seen, settings_used);
    $display("timeouts from 0 to 65535 ms, retry limits from 0 to 15, with and without stalls.");
    if (board.mismatches == 0 && board.due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
